// ===== sv/keypad_debounce_scanner_assert.svh =====
// Assertion macros shared by the keypad debounce scanner RTL.
// Each macro checks one property on the rising clock edge, with reset masking.
`ifndef KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH
`define KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define KDS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define KDS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

// Invariant: the expression must hold at every clock edge outside reset.
`define KDS_ASSERT_ALWAYS(label, ck, rn, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
		else $error(msg);

`endif

// ===== sv/kds_pkg.sv =====
`default_nettype none

package kds_pkg;

	// Physical keypad grid and the number of key sample bits.
	localparam int unsigned KEY_GRID     = 4;
	localparam int unsigned SAMPLE_BITS  = KEY_GRID * KEY_GRID;

	// Default geometry and debounce register value after reset.
	localparam int unsigned NUM_ROWS_DEF = 4;
	localparam int unsigned NUM_COLS_DEF = 4;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd40;

	// Operation codes carried by an input transaction.
	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Token that walks down the chain of key cells, one cell per cycle.
	typedef struct packed {
		logic       go;
		logic [6:0] code;
		logic       hit;
	} kds_tok_t;

	// ASCII legend of each key position on the keypad.
	function automatic logic [6:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
		logic [6:0] ch;
		unique case ({row, col})
			4'd0:    ch = 7'h31; // 1
			4'd1:    ch = 7'h32; // 2
			4'd2:    ch = 7'h33; // 3
			4'd3:    ch = 7'h41; // A
			4'd4:    ch = 7'h34; // 4
			4'd5:    ch = 7'h35; // 5
			4'd6:    ch = 7'h36; // 6
			4'd7:    ch = 7'h42; // B
			4'd8:    ch = 7'h37; // 7
			4'd9:    ch = 7'h38; // 8
			4'd10:   ch = 7'h39; // 9
			4'd11:   ch = 7'h43; // C
			4'd12:   ch = 7'h2A; // *
			4'd13:   ch = 7'h30; // 0
			4'd14:   ch = 7'h23; // #
			default: ch = 7'h44; // D
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== sv/kds_cell.sv =====
`default_nettype none

module kds_cell #(
	parameter logic [6:0] KEY_CODE = 7'h31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kds_pkg::kds_tok_t tok_in,
	input  wire logic             op,
	input  wire logic             sample,
	input  wire logic [31:0]      now,
	input  wire logic [6:0]       code,
	input  wire logic [15:0]      debounce,
	output kds_pkg::kds_tok_t     tok_out
);

	// Debounce phases of one key.
	localparam logic [1:0] PH_UP      = 2'd0;
	localparam logic [1:0] PH_FALLING = 2'd1;
	localparam logic [1:0] PH_DOWN    = 2'd2;
	localparam logic [1:0] PH_RISING  = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [31:0]       start_q, start_d;
	logic              run_q, run_d;
	logic              latch_q, latch_d;
	kds_pkg::kds_tok_t tok_q, tok_d;
	logic [31:0]       elapsed;
	logic              expired;

	// The one-shot timer has fired once the wrapped elapsed time reaches the wait.
	assign elapsed = now - start_q;
	assign expired = elapsed >= {16'd0, debounce};

	// Key update when the token reaches this cell.
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		run_d   = run_q;
		latch_d = latch_q;
		tok_d   = tok_in;
		if (tok_in.go) begin
			if (op == kds_pkg::OP_SCAN) begin
				unique case (phase_q) inside
					PH_UP: begin
						if (sample) phase_d = PH_FALLING;
					end
					PH_DOWN: begin
						if (!sample) phase_d = PH_RISING;
					end
					PH_FALLING, PH_RISING: begin
						if (!run_q) begin
							start_d = now;
							run_d   = 1'b1;
						end else if (expired) begin
							run_d = 1'b0;
							if (sample) begin
								phase_d = PH_DOWN;
								// Only a confirmed press sets the latch and reports.
								if (phase_q == PH_FALLING) begin
									latch_d    = 1'b1;
									tok_d.code = KEY_CODE;
								end
							end else begin
								phase_d = PH_UP;
							end
						end
					end
					default: phase_d = PH_UP;
				endcase
			end else if (code == KEY_CODE) begin
				tok_d.hit = latch_q;
				latch_d   = 1'b0;
			end
		end
	end

	// Key state and the token register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UP;
			start_q <= '0;
			run_q   <= 1'b0;
			latch_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			phase_q <= phase_d;
			start_q <= start_d;
			run_q   <= run_d;
			latch_q <= latch_d;
			tok_q   <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ===== sv/keypad_debounce_scanner.sv =====
// An accepted transaction passes through the start register, one token register per key cell and the
// done register before its result is offered in the output register. One transaction at a time: a
// token walks the chain one cell per cycle, and the next transaction enters once the result reaches the output.
// The input is taken while a finished result still waits in the output register.
// Reset: all keys up, timers stopped, latches clear, debounce_ms = 40; no clearing pass.
`default_nettype none

module keypad_debounce_scanner #(
	parameter int unsigned NUM_ROWS = kds_pkg::NUM_ROWS_DEF,
	parameter int unsigned NUM_COLS = kds_pkg::NUM_COLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [15:0] key_samples,
	input  wire logic [31:0] now_ms,
	input  wire logic [6:0]  key_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       pressed_code,
	output logic             was_pressed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	`include "keypad_debounce_scanner_assert.svh"

	localparam int unsigned NUM_KEYS = NUM_ROWS * NUM_COLS;

	logic                    busy_q;
	logic                    start_q;
	logic                    op_q;
	logic [15:0]             samples_q;
	logic [31:0]             now_q;
	logic [6:0]              code_q;
	logic [15:0]             debounce_q;
	logic                    done_valid_q;
	logic [6:0]              done_code_q;
	logic                    done_hit_q;
	logic                    out_valid_q;
	logic [6:0]              out_code_q;
	logic                    out_hit_q;
	logic                    in_accept;
	logic                    out_free;
	logic                    done_move;
	logic [NUM_KEYS-1:0]     go_vec;
	kds_pkg::kds_tok_t       tok [NUM_KEYS+1];

	// Handshakes: one transaction in flight; the config register is writable only while idle.
	assign in_stall  = busy_q;
	assign in_accept = in_valid & ~busy_q;
	assign cfg_ready = ~busy_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign done_move = done_valid_q & out_free;

	// Debounce register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kds_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	// Transaction holding registers, broadcast to every cell.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= operation;
			samples_q <= key_samples;
			now_q     <= now_ms;
			code_q    <= key_code;
		end
	end

	// Launch of the token and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_accept;
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (done_move) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok[0] = '{go: start_q, code: 7'd0, hit: 1'b0};

	// Chain of key cells in row-major scan order.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
			kds_cell #(
				.KEY_CODE(kds_pkg::key_ascii(2'(r), 2'(c)))
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok[r*NUM_COLS+c]),
				.op      (op_q),
				.sample  (samples_q[r*kds_pkg::KEY_GRID+c]),
				.now     (now_q),
				.code    (code_q),
				.debounce(debounce_q),
				.tok_out (tok[r*NUM_COLS+c+1])
			);
		end
	end

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_go
		assign go_vec[i] = tok[i+1].go;
	end

	// Result capture at the end of the chain and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tok[NUM_KEYS].go) begin
				done_valid_q <= 1'b1;
			end else if (done_move) begin
				done_valid_q <= 1'b0;
			end
			if (done_move) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[NUM_KEYS].go) begin
			done_code_q <= tok[NUM_KEYS].code;
			done_hit_q  <= tok[NUM_KEYS].hit;
		end
		if (done_move) begin
			out_code_q <= done_code_q;
			out_hit_q  <= done_hit_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pressed_code = out_code_q;
	assign was_pressed  = out_hit_q;

	// At most one token anywhere between launch and result capture.
	`KDS_ASSERT_ALWAYS(a_one_token, clk, arst_n, $onehot0({start_q, go_vec, done_valid_q}), "more than one token in flight")
	// Any token in flight belongs to the transaction that holds the block busy.
	`KDS_ASSERT_NOW(a_token_busy, clk, arst_n, start_q || (go_vec != '0) || done_valid_q, busy_q, "token without busy")
	// A new transaction starts its token on the next cycle.
	`KDS_ASSERT_NEXT(a_launch, clk, arst_n, in_accept, start_q && busy_q, "token not launched")
	// A result moved out of the chain is offered on the next cycle and frees the input.
	`KDS_ASSERT_NEXT(a_deliver, clk, arst_n, done_move, out_valid_q && !busy_q, "result not delivered")

endmodule

`default_nettype wire
